### hdl/ccf_pkg.sv
package ccf_pkg;

    localparam int unsigned COORD_W = 11;
    localparam int unsigned END_W   = COORD_W + 1;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned MAX_DIM = 2048;

    localparam int unsigned CLASS_N     = 3;
    localparam int unsigned CLASS_W     = 2;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = END_W;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CLASS_W-1:0] CLASS_BLUE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_YELLOW = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_RED    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_LIMIT  = 3'd6;

    localparam logic [COORD_W-1:0] RST_ROW_START  = '0;
    localparam logic [END_W-1:0]   RST_ROW_END    = END_W'(MAX_DIM);
    localparam logic [COORD_W-1:0] RST_COL_START  = '0;
    localparam logic [END_W-1:0]   RST_COL_END    = END_W'(MAX_DIM);
    localparam logic [CHAN_W-1:0]  RST_DARK_MAX   = 8'd50;
    localparam logic [CHAN_W-1:0]  RST_BRIGHT_MIN = 8'd200;
    localparam logic [CHAN_W-1:0]  RST_RED_LIMIT  = 8'd90;

    // Per class summary of one frame. For red, col_a is the first column
    // matched in the row of the latest red match; otherwise the first column.
    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] first_row;
        logic [COORD_W-1:0] last_row;
        logic [COORD_W-1:0] col_a;
        logic [COORD_W-1:0] col_b;
    } t_class_rec;

    typedef struct packed {
        t_class_rec [CLASS_N-1:0] cls;
    } t_frame_rec;

endpackage

### hdl/ccf_front.sv
module ccf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [ccf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ccf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_accept,
    input  logic [ccf_pkg::CHAN_W-1:0]       i_blue,
    input  logic [ccf_pkg::CHAN_W-1:0]       i_green,
    input  logic [ccf_pkg::CHAN_W-1:0]       i_red,
    input  logic [ccf_pkg::COORD_W-1:0]      i_pixel_row,
    input  logic [ccf_pkg::COORD_W-1:0]      i_pixel_col,
    input  logic                             i_frame_end,
    output logic                             o_q_push,
    output ccf_pkg::t_frame_rec              o_q_data
);

    localparam int unsigned N  = ccf_pkg::CLASS_N;
    localparam int unsigned CW = ccf_pkg::COORD_W;

    logic [CW-1:0]              r_row_start, r_col_start;
    logic [ccf_pkg::END_W-1:0]  r_row_end, r_col_end;
    logic [ccf_pkg::CHAN_W-1:0] r_dark_max, r_bright_min, r_red_limit;

    logic [N-1:0]  r_seen, n_seen;
    logic [CW-1:0] r_first_row [N];
    logic [CW-1:0] r_first_col [N];
    logic [CW-1:0] r_last_row  [N];
    logic [CW-1:0] r_last_col  [N];
    logic [CW-1:0] n_first_row [N];
    logic [CW-1:0] n_first_col [N];
    logic [CW-1:0] n_last_row  [N];
    logic [CW-1:0] n_last_col  [N];
    logic [CW-1:0] r_red_row_first, n_red_row_first;

    logic         in_window;
    logic         is_blue, is_yellow, is_red;
    logic [N-1:0] hit;

    always_comb begin
        in_window = (i_pixel_row >= r_row_start) && ({1'b0, i_pixel_row} < r_row_end)
                 && (i_pixel_col >= r_col_start) && ({1'b0, i_pixel_col} < r_col_end);
        is_blue   = (i_green <= r_dark_max) && (i_red <= r_dark_max);
        is_yellow = (i_blue <= r_dark_max) && (i_green >= r_bright_min)
                 && (i_red >= r_bright_min);
        is_red    = (i_blue <= r_red_limit) && (i_green <= r_red_limit);
        hit = '0;
        if (i_accept && in_window) begin
            priority if (is_blue) begin
                hit[ccf_pkg::CLASS_BLUE] = 1'b1;
            end else if (is_yellow) begin
                hit[ccf_pkg::CLASS_YELLOW] = 1'b1;
            end else if (is_red) begin
                hit[ccf_pkg::CLASS_RED] = 1'b1;
            end else begin
                hit = '0;
            end
        end
    end

    always_comb begin
        n_seen          = r_seen;
        n_red_row_first = r_red_row_first;
        for (int k = 0; k < N; k++) begin
            n_first_row[k] = r_first_row[k];
            n_first_col[k] = r_first_col[k];
            n_last_row[k]  = r_last_row[k];
            n_last_col[k]  = r_last_col[k];
            if (hit[k]) begin
                if (!r_seen[k]) begin
                    n_seen[k]      = 1'b1;
                    n_first_row[k] = i_pixel_row;
                    n_first_col[k] = i_pixel_col;
                end
                n_last_row[k] = i_pixel_row;
                n_last_col[k] = i_pixel_col;
            end
        end
        // The red row-first column restarts on every red match in a new row.
        if (hit[ccf_pkg::CLASS_RED] && (!r_seen[ccf_pkg::CLASS_RED]
                || r_last_row[ccf_pkg::CLASS_RED] != i_pixel_row)) begin
            n_red_row_first = i_pixel_col;
        end
    end

    always_comb begin
        o_q_push = i_accept && i_frame_end;
        for (int k = 0; k < N; k++) begin
            o_q_data.cls[k].found     = n_seen[k];
            o_q_data.cls[k].first_row = n_first_row[k];
            o_q_data.cls[k].last_row  = n_last_row[k];
            o_q_data.cls[k].col_a     = (k == int'(ccf_pkg::CLASS_RED)) ? n_red_row_first
                                                                        : n_first_col[k];
            o_q_data.cls[k].col_b     = n_last_col[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_start  <= ccf_pkg::RST_ROW_START;
            r_row_end    <= ccf_pkg::RST_ROW_END;
            r_col_start  <= ccf_pkg::RST_COL_START;
            r_col_end    <= ccf_pkg::RST_COL_END;
            r_dark_max   <= ccf_pkg::RST_DARK_MAX;
            r_bright_min <= ccf_pkg::RST_BRIGHT_MIN;
            r_red_limit  <= ccf_pkg::RST_RED_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ccf_pkg::CFG_ROW_START:  r_row_start  <= i_cfg_data[CW-1:0];
                ccf_pkg::CFG_ROW_END:    r_row_end    <= i_cfg_data;
                ccf_pkg::CFG_COL_START:  r_col_start  <= i_cfg_data[CW-1:0];
                ccf_pkg::CFG_COL_END:    r_col_end    <= i_cfg_data;
                ccf_pkg::CFG_DARK_MAX:   r_dark_max   <= i_cfg_data[ccf_pkg::CHAN_W-1:0];
                ccf_pkg::CFG_BRIGHT_MIN: r_bright_min <= i_cfg_data[ccf_pkg::CHAN_W-1:0];
                ccf_pkg::CFG_RED_LIMIT:  r_red_limit  <= i_cfg_data[ccf_pkg::CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Trackers clear on the end-of-frame pixel once its summary is queued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_q_push) begin
            r_seen          <= '0;
            r_red_row_first <= '0;
            for (int k = 0; k < N; k++) begin
                r_first_row[k] <= '0;
                r_first_col[k] <= '0;
                r_last_row[k]  <= '0;
                r_last_col[k]  <= '0;
            end
        end else begin
            r_seen          <= n_seen;
            r_red_row_first <= n_red_row_first;
            for (int k = 0; k < N; k++) begin
                r_first_row[k] <= n_first_row[k];
                r_first_col[k] <= n_first_col[k];
                r_last_row[k]  <= n_last_row[k];
                r_last_col[k]  <= n_last_col[k];
            end
        end
    end

endmodule

### hdl/ccf_queue.sv
module ccf_queue #(
    parameter int unsigned DEPTH = ccf_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ccf_pkg::t_frame_rec  i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output ccf_pkg::t_frame_rec  o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ccf_pkg::t_frame_rec r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/ccf_back.sv
module ccf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  ccf_pkg::t_frame_rec            i_q_data,
    output logic                           o_q_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [ccf_pkg::CLASS_W-1:0]    o_shape_class,
    output logic                           o_found,
    output logic [ccf_pkg::COORD_W-1:0]    o_center_row,
    output logic [ccf_pkg::COORD_W-1:0]    o_center_col,
    output logic                           o_last_result
);

    localparam int unsigned CW = ccf_pkg::COORD_W;

    ccf_pkg::t_frame_rec          r_rec;
    logic                         r_busy;
    logic [ccf_pkg::CLASS_W-1:0]  r_cls;
    logic                         r_out_valid;

    ccf_pkg::t_class_rec cur;
    logic                out_free;
    logic                load_out;
    logic                cls_done;
    logic [CW:0]         row_sum, col_sum;

    always_comb begin
        unique case (r_cls)
            ccf_pkg::CLASS_BLUE:   cur = r_rec.cls[ccf_pkg::CLASS_BLUE];
            ccf_pkg::CLASS_YELLOW: cur = r_rec.cls[ccf_pkg::CLASS_YELLOW];
            ccf_pkg::CLASS_RED:    cur = r_rec.cls[ccf_pkg::CLASS_RED];
            default:               cur = '0;
        endcase
        row_sum = {1'b0, cur.first_row} + {1'b0, cur.last_row};
        col_sum = {1'b0, cur.col_a} + {1'b0, cur.col_b};
    end

    assign out_free = !r_out_valid || i_pop;
    assign load_out = r_busy && out_free;
    assign cls_done = load_out && (r_cls == ccf_pkg::CLASS_RED);
    assign o_q_pop  = !i_q_empty && (!r_busy || cls_done);
    assign o_empty  = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cls       <= ccf_pkg::CLASS_BLUE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_cls  <= ccf_pkg::CLASS_BLUE;
            end else if (cls_done) begin
                r_busy <= 1'b0;
            end else if (load_out) begin
                r_cls <= r_cls + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_data;
        end
        if (load_out) begin
            o_shape_class <= r_cls;
            o_found       <= cur.found;
            o_center_row  <= cur.found ? row_sum[CW:1] : '0;
            o_center_col  <= cur.found ? col_sum[CW:1] : '0;
            o_last_result <= (r_cls == ccf_pkg::CLASS_RED);
        end
    end

endmodule

### hdl/color_class_center_finder.sv
// Color class center finder. Takes one pixel per clock in raster order, tests
// it against the search window and the blue, yellow and red thresholds, and
// tracks the first and last match of each class. The end-of-frame pixel is
// classified and then its frame summary moves into a frame queue of
// QUEUE_DEPTH entries, after which the trackers start the next frame at once.
// Each summary drains as three results (blue, yellow, red, the red one with
// last_result set), one per clock while pop is held. full rises only when the
// frame queue holds QUEUE_DEPTH frames whose results are not yet drained, so
// a reader that keeps up sees one pixel accepted every cycle as long as frames
// are at least three pixels long, with the first result of a frame on the
// ports after the queue, drain and output registers. Shorter frames arrive
// faster than their three results drain and fill the queue.
// Configuration is taken in the cycle it is offered; write it between frames.
module color_class_center_finder #(
    parameter int unsigned QUEUE_DEPTH = ccf_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ccf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ccf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [ccf_pkg::CHAN_W-1:0]       i_blue,
    input  logic [ccf_pkg::CHAN_W-1:0]       i_green,
    input  logic [ccf_pkg::CHAN_W-1:0]       i_red,
    input  logic [ccf_pkg::COORD_W-1:0]      i_pixel_row,
    input  logic [ccf_pkg::COORD_W-1:0]      i_pixel_col,
    input  logic                             i_frame_end,
    input  logic                             pop,
    output logic                             empty,
    output logic [ccf_pkg::CLASS_W-1:0]      o_shape_class,
    output logic                             o_found,
    output logic [ccf_pkg::COORD_W-1:0]      o_center_row,
    output logic [ccf_pkg::COORD_W-1:0]      o_center_col,
    output logic                             o_last_result
);

    logic                q_push, q_pop, q_full, q_empty;
    ccf_pkg::t_frame_rec q_wr_data, q_rd_data;
    logic                accept;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    ccf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_frame_end (i_frame_end),
        .o_q_push    (q_push),
        .o_q_data    (q_wr_data)
    );

    ccf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    ccf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rd_data),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_shape_class (o_shape_class),
        .o_found       (o_found),
        .o_center_row  (o_center_row),
        .o_center_col  (o_center_col),
        .o_last_result (o_last_result)
    );

    a_last_is_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_result == (o_shape_class == ccf_pkg::CLASS_RED)))
        else $error("last_result does not match the red result");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |-> (o_center_row == '0 && o_center_col == '0))
        else $error("center not zero for a class without match");

    a_blue_then_yellow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_shape_class == ccf_pkg::CLASS_BLUE)
        |=> (!empty && o_shape_class == ccf_pkg::CLASS_YELLOW))
        else $error("yellow result did not follow blue");

    a_yellow_then_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_shape_class == ccf_pkg::CLASS_YELLOW)
        |=> (!empty && o_shape_class == ccf_pkg::CLASS_RED))
        else $error("red result did not follow yellow");

endmodule
